>>> rtl/wip_pkg.sv
package wip_pkg;

    // Default number of fraction bits for speeds, errors and the drive value
    localparam int FRAC_BITS_DEF = 8;

    // Gains are Q8.8
    localparam int GAIN_FRAC = 8;

    // 0.448 and 1.56 scaled by 2^16, truncated
    localparam int SCALE_Q16  = 29360;
    localparam int OFFSET_Q16 = 102236;

    localparam int LIMIT_WHOLE = 95;
    localparam int NEAR_WHOLE  = 5;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SPEED = 2'd3;

    typedef enum logic [1:0] {
        MUL_CONV,
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     speed_en;
        acc_op_t  acc_op;
        logic     fin_en;
    } cmd_t;

endpackage

>>> rtl/wip_ctrl.sv
module wip_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output wip_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SPEED,
        S_MULP,
        S_MULI,
        S_MULD,
        S_ACCD,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        cmd              = '0;
        cmd.mul_sel      = wip_pkg::MUL_CONV;
        cmd.acc_op       = wip_pkg::ACC_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CONV;
                end
            end
            S_CONV: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wip_pkg::MUL_CONV;
                state_next  = S_SPEED;
            end
            S_SPEED: begin
                cmd.speed_en = 1'b1;
                state_next   = S_MULP;
            end
            S_MULP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wip_pkg::MUL_PROP;
                state_next  = S_MULI;
            end
            S_MULI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wip_pkg::MUL_INTEG;
                cmd.acc_op  = wip_pkg::ACC_ADD;
                state_next  = S_MULD;
            end
            S_MULD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wip_pkg::MUL_DERIV;
                cmd.acc_op  = wip_pkg::ACC_ADD;
                state_next  = S_ACCD;
            end
            S_ACCD: begin
                cmd.acc_op = wip_pkg::ACC_SUB;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    cmd.fin_en    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a transfer");

    a_fin_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_en |-> out_free)
        else $error("result loaded over an untaken result");

    a_fin_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_en |=> m_tvalid)
        else $error("finished result not offered");

    a_acc_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_op != wip_pkg::ACC_NONE |-> $past(cmd.mul_en))
        else $error("accumulate without a fresh product");
`endif

endmodule

>>> rtl/wip_datapath.sv
module wip_datapath #(
    parameter int FRAC_BITS = wip_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [wip_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wip_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [15:0]                    count_in,
    input  wip_pkg::cmd_t                  cmd,
    output logic [15:0]                    drive,
    output logic                           clamped,
    output logic                           near_target
);

    // operand width for speeds, errors and differences
    localparam int W     = FRAC_BITS + 17;
    localparam int PW    = W + 16;
    localparam int SUM_W = FRAC_BITS + 28;
    localparam int ACC_W = FRAC_BITS + 8;
    localparam int SHIFT = 16 - FRAC_BITS;

    localparam longint LIMIT_VAL = longint'(wip_pkg::LIMIT_WHOLE) << FRAC_BITS;
    localparam longint NEAR_VAL  = longint'(wip_pkg::NEAR_WHOLE) << FRAC_BITS;

    localparam logic signed [SUM_W-1:0] LIMIT     = SUM_W'(LIMIT_VAL);
    localparam logic signed [SUM_W-1:0] NEG_LIMIT = -LIMIT;
    localparam logic signed [W-1:0]     NEAR      = W'(NEAR_VAL);
    localparam logic signed [PW-1:0]    OFFSET    = PW'(wip_pkg::OFFSET_Q16);
    localparam logic signed [15:0]      SCALE     = 16'(wip_pkg::SCALE_Q16);

    logic signed [15:0]      prop_gain_reg;
    logic signed [15:0]      integ_gain_reg;
    logic signed [15:0]      deriv_gain_reg;
    logic signed [15:0]      target_reg;

    logic signed [W-1:0]     speed_now_reg;
    logic signed [W-1:0]     speed_prev_reg;
    logic signed [W-1:0]     error_prev_reg;
    logic signed [ACC_W-1:0] drive_accum_reg;

    logic signed [15:0]      count_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [W-1:0]     err_reg;
    logic signed [W-1:0]     ediff_reg;
    logic signed [W-1:0]     diff2_reg;
    logic signed [SUM_W-1:0] incr_reg;
    logic                    close_reg;
    logic [15:0]             drive_reg;
    logic                    clamped_reg;
    logic                    near_reg;

    logic signed [15:0]      mul_a;
    logic signed [W-1:0]     mul_b;
    logic signed [PW-1:0]    mul_p;

    logic signed [PW-1:0]    q16;
    logic signed [PW-1:0]    q16_sh;
    logic signed [W-1:0]     speed_c;
    logic signed [W-1:0]     target_w;
    logic signed [W-1:0]     err_c;
    logic signed [W-1:0]     ediff_c;
    logic signed [W-1:0]     diff2_c;
    logic signed [W-1:0]     dist_c;
    logic signed [W-1:0]     dist_abs;
    logic                    close_c;

    logic signed [SUM_W-1:0] term_c;
    logic signed [SUM_W-1:0] sum_c;
    logic signed [SUM_W-1:0] sum_lim;
    logic signed [SUM_W-1:0] target_s;
    logic signed [SUM_W-1:0] target_lim;
    logic signed [SUM_W-1:0] drive_new;
    logic                    hit_c;

    // shared multiplier operand select
    always_comb begin
        unique case (cmd.mul_sel)
            wip_pkg::MUL_CONV: begin
                mul_a = SCALE;
                mul_b = W'(count_reg);
            end
            wip_pkg::MUL_PROP: begin
                mul_a = prop_gain_reg;
                mul_b = ediff_reg;
            end
            wip_pkg::MUL_INTEG: begin
                mul_a = integ_gain_reg;
                mul_b = err_reg;
            end
            wip_pkg::MUL_DERIV: begin
                mul_a = deriv_gain_reg;
                mul_b = diff2_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // speed, error and second difference from the conversion product
    assign q16      = prod_reg - OFFSET;
    assign q16_sh   = q16 >>> SHIFT;
    assign speed_c  = q16_sh[W-1:0];
    assign target_w = W'(target_reg);
    assign err_c    = target_w - speed_c;
    assign ediff_c  = err_c - error_prev_reg;
    assign diff2_c  = speed_c - (speed_now_reg <<< 1) + speed_prev_reg;
    assign dist_c   = speed_c - target_w;
    assign dist_abs = dist_c[W-1] ? -dist_c : dist_c;
    assign close_c  = dist_abs < NEAR;

    assign term_c = SUM_W'(prod_reg >>> wip_pkg::GAIN_FRAC);

    // limit the accumulated value, then apply the near-target override
    assign sum_c    = SUM_W'(drive_accum_reg) + incr_reg;
    assign target_s = SUM_W'(target_reg);

    always_comb begin
        hit_c   = 1'b0;
        sum_lim = sum_c;
        if (sum_c > LIMIT) begin
            hit_c   = 1'b1;
            sum_lim = LIMIT;
        end else if (sum_c < NEG_LIMIT) begin
            hit_c   = 1'b1;
            sum_lim = NEG_LIMIT;
        end
        target_lim = target_s;
        if (target_s > LIMIT) begin
            target_lim = LIMIT;
        end else if (target_s < NEG_LIMIT) begin
            target_lim = NEG_LIMIT;
        end
        drive_new = close_reg ? target_lim : sum_lim;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            target_reg      <= '0;
            speed_now_reg   <= '0;
            speed_prev_reg  <= '0;
            error_prev_reg  <= '0;
            drive_accum_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    wip_pkg::REG_PROP_GAIN:    prop_gain_reg  <= cfg_wdata;
                    wip_pkg::REG_INTEG_GAIN:   integ_gain_reg <= cfg_wdata;
                    wip_pkg::REG_DERIV_GAIN:   deriv_gain_reg <= cfg_wdata;
                    wip_pkg::REG_TARGET_SPEED: target_reg     <= cfg_wdata;
                endcase
            end
            if (cmd.speed_en) begin
                speed_now_reg  <= speed_c;
                speed_prev_reg <= speed_now_reg;
                error_prev_reg <= err_c;
            end
            if (cmd.fin_en) begin
                drive_accum_reg <= drive_new[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            count_reg <= count_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.speed_en) begin
            err_reg   <= err_c;
            ediff_reg <= ediff_c;
            diff2_reg <= diff2_c;
            close_reg <= close_c;
            incr_reg  <= '0;
        end else begin
            unique case (cmd.acc_op)
                wip_pkg::ACC_ADD:  incr_reg <= incr_reg + term_c;
                wip_pkg::ACC_SUB:  incr_reg <= incr_reg - term_c;
                wip_pkg::ACC_NONE: incr_reg <= incr_reg;
                default:           incr_reg <= incr_reg;
            endcase
        end
        if (cmd.fin_en) begin
            drive_reg   <= drive_new[15:0];
            clamped_reg <= hit_c;
            near_reg    <= close_reg;
        end
    end

    assign drive       = drive_reg;
    assign clamped     = clamped_reg;
    assign near_target = near_reg;

endmodule

>>> rtl/wheel_incremental_pid.sv
// Incremental PID speed loop for one wheel, derivative on measurement. Each
// encoder count transfer yields one drive transfer: the count is taken in
// idle, then four passes go through the single shared 16 x (FRAC_BITS+17)
// signed multiplier (speed conversion, then the proportional, integral and
// derivative products) interleaved with the speed/error step and the
// accumulate steps, and a last step limits the drive and loads the output
// register once it is free. The controller works on one count at a time and
// takes the next as soon as it is back in idle, so a new transfer may be
// accepted while the previous result still waits on the output; that result
// must be taken before the next one can be written. Configuration writes of
// gains and target act at once, so one made mid-sample can reach that sample.
module wheel_incremental_pid #(
    parameter int FRAC_BITS = wip_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [wip_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wip_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // encoder count stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // [15:0] encoder_count
    // drive stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // [15:0] drive
    output logic [1:0]                     m_tuser   // [0] clamped, [1] near_target
);

    wip_pkg::cmd_t cmd;
    logic          clamped;
    logic          near_target;

    wip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    wip_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .count_in    (s_tdata),
        .cmd         (cmd),
        .drive       (m_tdata),
        .clamped     (clamped),
        .near_target (near_target)
    );

    assign m_tuser = {near_target, clamped};

endmodule
